[hw/rtl/sac_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// sac_pkg: shared types and constants of the set-associative cache model
// Command and outcome codes, register indexes, field widths, reset values of
// the configuration registers and the top-level sequencer states.
// ----------------------------------------------------------------------------
package sac_pkg;

	// Field widths of the transaction channels
	localparam int CMD_W   = 2;
	localparam int ADDR_W  = 32;
	localparam int OUTC_W  = 2;
	localparam int TOTAL_W = 32;
	localparam int STAMP_W = 32;

	// Configuration port
	localparam int PADDR_W = 4;
	localparam int PDATA_W = 32;
	localparam int SET_BITS_W    = 4;
	localparam int OFFSET_BITS_W = 5;
	localparam int WAYS_CFG_W    = 4;

	localparam logic [SET_BITS_W-1:0]    SET_BITS_RST    = SET_BITS_W'(4);
	localparam logic [OFFSET_BITS_W-1:0] OFFSET_BITS_RST = OFFSET_BITS_W'(4);
	localparam logic [WAYS_CFG_W-1:0]    WAYS_RST        = WAYS_CFG_W'(1);

	typedef enum logic [1:0] {
		REG_SET_BITS    = 2'd0,
		REG_OFFSET_BITS = 2'd1,
		REG_WAYS        = 2'd2
	} reg_idx_t;

	typedef enum logic [CMD_W-1:0] {
		CMD_LOAD   = 2'd0,
		CMD_STORE  = 2'd1,
		CMD_MODIFY = 2'd2,
		CMD_FETCH  = 2'd3
	} cmd_t;

	typedef enum logic [OUTC_W-1:0] {
		OUT_HIT   = 2'd0,
		OUT_FILL  = 2'd1,
		OUT_EVICT = 2'd2
	} outcome_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SPLIT,
		ST_READ,
		ST_SCAN,
		ST_UPDATE
	} state_t;

	// Raw register values as written, clamped where they are used
	typedef struct packed {
		logic [SET_BITS_W-1:0]    index_len;
		logic [OFFSET_BITS_W-1:0] offset_len;
		logic [WAYS_CFG_W-1:0]    ways;
	} cfg_t;

endpackage
`default_nettype wire

[hw/rtl/sac_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// sac_if: request and response channels of the cache model
// Valid/ready channels; a transaction moves on a rising edge with both high.
// ----------------------------------------------------------------------------
interface sac_req_if;
	import sac_pkg::*;
	logic              valid;
	logic              ready;
	logic [CMD_W-1:0]  command;
	logic [ADDR_W-1:0] address;
	modport source (output valid, command, address, input ready);
	modport sink   (input valid, command, address, output ready);
endinterface

interface sac_rsp_if;
	import sac_pkg::*;
	logic               valid;
	logic               ready;
	logic [OUTC_W-1:0]  outcome;
	logic               second_hit;
	logic [TOTAL_W-1:0] hit_total;
	logic [TOTAL_W-1:0] miss_total;
	logic [TOTAL_W-1:0] eviction_total;
	modport source (output valid, outcome, second_hit, hit_total, miss_total,
		eviction_total, input ready);
	modport sink   (input valid, outcome, second_hit, hit_total, miss_total,
		eviction_total, output ready);
endinterface
`default_nettype wire

[hw/rtl/set_assoc_cache_lru_sim_top.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// set_assoc_cache_lru_sim_top: set-associative cache with LRU replacement
// Looks up each access in its set, fills or evicts, and reports the outcome
// with saturating hit, miss and eviction totals.
// ----------------------------------------------------------------------------
// A load, store or modify is accepted, then the address is split, the set's
// row is read, the single tag and stamp compare unit walks the ways in use
// one after another, and the row is written back while the result register
// is loaded; the next access is accepted only after the write-back. The
// write-back waits for as long as the previous result is still unread. An
// instruction fetch is accepted and dropped. After reset a clearing pass
// empties every line; no access is accepted until it ends, while
// configuration writes are taken. Lines stay as they are across
// configuration changes.
// ----------------------------------------------------------------------------
module set_assoc_cache_lru_sim_top #(
	parameter int MAX_SET_BITS = 8,
	parameter int MAX_WAYS     = 8,
	parameter int ADDR_WIDTH   = 32
) (
	input  logic                         clk,
	input  logic                         arst_n,
	sac_req_if.sink                      req,
	sac_rsp_if.source                    rsp,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [sac_pkg::PADDR_W-1:0]  paddr,
	input  logic [sac_pkg::PDATA_W-1:0]  pwdata,
	output logic [sac_pkg::PDATA_W-1:0]  prdata,
	output logic                         pready
);
	import sac_pkg::*;

	localparam int EFF_AW = (ADDR_WIDTH < ADDR_W) ? ADDR_WIDTH : ADDR_W;
	localparam int TAG_W  = EFF_AW - 1;
	localparam int SET_W  = MAX_SET_BITS;
	localparam int WAY_W  = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
	localparam int WCNT_W = WAYS_CFG_W + 1;
	localparam int SH_W   = OFFSET_BITS_W + 1;

	localparam logic [SET_BITS_W-1:0] MAX_SB = SET_BITS_W'(MAX_SET_BITS);
	localparam logic [WCNT_W-1:0]     MAX_WY = WCNT_W'(MAX_WAYS);

	typedef struct packed {
		logic               valid;
		logic [TAG_W-1:0]   tag;
		logic [STAMP_W-1:0] stamp;
	} line_t;
	typedef line_t [MAX_WAYS-1:0] row_t;

	localparam int ROW_W = $bits(row_t);

	cfg_t   cfg;
	state_t state_q, state_d;

	logic [CMD_W-1:0]   cmd_q;
	logic [EFF_AW-1:0]  addr_q;
	logic [SET_W-1:0]   set_q;
	logic [TAG_W-1:0]   tag_q;
	logic [WAY_W-1:0]   w_q;
	logic               found_q, empty_q;
	logic [WAY_W-1:0]   found_way_q, empty_way_q, lru_way_q;
	logic [STAMP_W-1:0] old_q;
	logic [STAMP_W-1:0] clock_q;
	logic [TOTAL_W-1:0] hit_q, miss_q, evict_q;

	logic               rsp_valid_q;
	logic [OUTC_W-1:0]  outcome_q;
	logic               second_q;
	logic [TOTAL_W-1:0] hit_tot_q, miss_tot_q, evict_tot_q;

	logic               accept, start, commit;
	logic               mem_rd_en, mem_wr_en, mem_busy;
	logic [ROW_W-1:0]   mem_rd_data;
	row_t               rd_row, new_row;

	// Configuration registers
	sac_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Clamp the registers to their working ranges
	logic [SET_BITS_W-1:0]    s_eff;
	logic [OFFSET_BITS_W-1:0] b_eff;
	logic [WCNT_W-1:0]        ways_raw, ways_eff;
	logic [WAY_W-1:0]         ways_last;
	logic [SH_W-1:0]          sh_tag;
	logic [SET_W-1:0]         set_mask, set_d;
	logic [TAG_W-1:0]         tag_d;

	always_comb begin
		s_eff = cfg.index_len;
		if (cfg.index_len == '0) begin
			s_eff = SET_BITS_W'(1);
		end else if (cfg.index_len > MAX_SB) begin
			s_eff = MAX_SB;
		end
		b_eff    = (cfg.offset_len == '0) ? OFFSET_BITS_W'(1) : cfg.offset_len;
		ways_raw = {1'b0, cfg.ways};
		ways_eff = ways_raw;
		if (ways_raw == '0) begin
			ways_eff = WCNT_W'(1);
		end else if (ways_raw > MAX_WY) begin
			ways_eff = MAX_WY;
		end
		ways_last = WAY_W'(ways_eff - WCNT_W'(1));
	end

	// Split the address into set index and tag
	assign sh_tag   = SH_W'(s_eff) + SH_W'(b_eff);
	assign set_mask = ~({SET_W{1'b1}} << s_eff);
	assign set_d    = SET_W'(addr_q >> b_eff) & set_mask;
	assign tag_d    = TAG_W'(addr_q >> sh_tag);

	// Line store
	sac_mem #(
		.ROW_W     (ROW_W),
		.ADDR_BITS (SET_W)
	) u_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (mem_rd_en),
		.rd_addr (set_q),
		.rd_data (mem_rd_data),
		.wr_en   (mem_wr_en),
		.wr_addr (set_q),
		.wr_data (new_row),
		.busy    (mem_busy)
	);

	assign rd_row = mem_rd_data;

	// Sequencer outputs
	always_comb begin
		req.ready = (state_q == ST_IDLE) && !mem_busy;
		mem_rd_en = (state_q == ST_READ);
		commit    = (state_q == ST_UPDATE) && (!rsp_valid_q || rsp.ready);
		mem_wr_en = commit;
	end

	assign accept = req.valid && req.ready;
	assign start  = accept && (cmd_t'(req.command) != CMD_FETCH);

	// Sequencer next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:   if (start) state_d = ST_SPLIT;
			ST_SPLIT:  state_d = ST_READ;
			ST_READ:   state_d = ST_SCAN;
			ST_SCAN:   if (w_q == ways_last) state_d = ST_UPDATE;
			ST_UPDATE: if (commit) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Shared compare unit: one way per cycle
	line_t cur_line;
	logic  cur_match, cur_older, first_step;

	assign cur_line   = rd_row[w_q];
	assign cur_match  = cur_line.valid && (cur_line.tag == tag_q);
	assign cur_older  = cur_line.stamp < old_q;
	assign first_step = (w_q == '0);

	// Capture the access, split it, walk the set
	always_ff @(posedge clk) begin
		if (start) begin
			cmd_q  <= req.command;
			addr_q <= req.address[EFF_AW-1:0];
		end
		if (state_q == ST_SPLIT) begin
			set_q <= set_d;
			tag_q <= tag_d;
		end
		if (state_q == ST_READ) begin
			w_q <= '0;
		end
		if (state_q == ST_SCAN) begin
			w_q <= w_q + 1'b1;
			if (first_step) begin
				found_q     <= cur_match;
				found_way_q <= '0;
				empty_q     <= !cur_line.valid;
				empty_way_q <= '0;
				old_q       <= cur_line.stamp;
				lru_way_q   <= '0;
			end else begin
				if (!found_q && cur_match) begin
					found_q     <= 1'b1;
					found_way_q <= w_q;
				end
				if (!empty_q && !cur_line.valid) begin
					empty_q     <= 1'b1;
					empty_way_q <= w_q;
				end
				if (cur_older) begin
					old_q     <= cur_line.stamp;
					lru_way_q <= w_q;
				end
			end
		end
	end

	// Build the row to write back and the new totals
	logic [WAY_W-1:0]   victim;
	logic               is_mod;
	logic [1:0]         hit_inc;
	logic [TOTAL_W:0]   hit_sum;
	logic [TOTAL_W-1:0] hit_d, miss_d, evict_d;
	logic [OUTC_W-1:0]  outcome_d;

	always_comb begin
		victim  = empty_q ? empty_way_q : lru_way_q;
		new_row = rd_row;
		if (found_q) begin
			new_row[found_way_q].stamp = clock_q;
		end else begin
			new_row[victim].valid = 1'b1;
			new_row[victim].tag   = tag_q;
			new_row[victim].stamp = clock_q;
		end
		is_mod  = (cmd_t'(cmd_q) == CMD_MODIFY);
		hit_inc = 2'(found_q) + 2'(is_mod);
		hit_sum = {1'b0, hit_q} + (TOTAL_W+1)'(hit_inc);
		hit_d   = hit_sum[TOTAL_W] ? '1 : hit_sum[TOTAL_W-1:0];
		miss_d  = (!found_q && (miss_q != '1)) ? miss_q + 1'b1 : miss_q;
		evict_d = (!found_q && !empty_q && (evict_q != '1)) ? evict_q + 1'b1 : evict_q;
		if (found_q) begin
			outcome_d = OUT_HIT;
		end else if (empty_q) begin
			outcome_d = OUT_FILL;
		end else begin
			outcome_d = OUT_EVICT;
		end
	end

	// Hold the use clock and totals
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clock_q <= '0;
			hit_q   <= '0;
			miss_q  <= '0;
			evict_q <= '0;
		end else if (commit) begin
			clock_q <= clock_q + 1'b1;
			hit_q   <= hit_d;
			miss_q  <= miss_d;
			evict_q <= evict_d;
		end
	end

	// Result register, free again once its transaction completes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (commit) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			outcome_q   <= outcome_d;
			second_q    <= is_mod;
			hit_tot_q   <= hit_d;
			miss_tot_q  <= miss_d;
			evict_tot_q <= evict_d;
		end
	end

	assign rsp.valid          = rsp_valid_q;
	assign rsp.outcome        = outcome_q;
	assign rsp.second_hit     = second_q;
	assign rsp.hit_total      = hit_tot_q;
	assign rsp.miss_total     = miss_tot_q;
	assign rsp.eviction_total = evict_tot_q;

`ifndef SYNTHESIS
	a_no_access_while_clearing: assert property (@(posedge clk) disable iff (!arst_n)
		mem_busy |-> !req.ready)
		else $error("access channel ready during clearing pass");

	a_result_from_update: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> $past(state_q == ST_UPDATE))
		else $error("result appeared without a write-back");

	a_totals_monotone: assert property (@(posedge clk) disable iff (!arst_n)
		(hit_q >= $past(hit_q)) && (miss_q >= $past(miss_q)))
		else $error("hit or miss total went down");

	a_evict_within_miss: assert property (@(posedge clk) disable iff (!arst_n)
		evict_q <= miss_q)
		else $error("eviction total exceeds miss total");

	a_scan_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> (w_q <= ways_last))
		else $error("way walk ran past the ways in use");
`endif

endmodule
`default_nettype wire

[hw/rtl/sac_cfg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// sac_cfg: configuration register file
// APB-style slave holding set index bits, block offset bits and ways in use.
// ----------------------------------------------------------------------------
module sac_cfg (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [sac_pkg::PADDR_W-1:0]  paddr,
	input  logic [sac_pkg::PDATA_W-1:0]  pwdata,
	output logic [sac_pkg::PDATA_W-1:0]  prdata,
	output logic                         pready,
	output sac_pkg::cfg_t                cfg
);
	import sac_pkg::*;

	cfg_t     cfg_q;
	logic     wr_en;
	reg_idx_t idx;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;
	assign idx    = reg_idx_t'(paddr[PADDR_W-1:2]);
	assign cfg    = cfg_q;

	// Write the addressed register; drop writes beyond the map
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.index_len  <= SET_BITS_RST;
			cfg_q.offset_len <= OFFSET_BITS_RST;
			cfg_q.ways       <= WAYS_RST;
		end else if (wr_en) begin
			unique case (idx)
				REG_SET_BITS:    cfg_q.index_len  <= pwdata[SET_BITS_W-1:0];
				REG_OFFSET_BITS: cfg_q.offset_len <= pwdata[OFFSET_BITS_W-1:0];
				REG_WAYS:        cfg_q.ways       <= pwdata[WAYS_CFG_W-1:0];
				default: ;
			endcase
		end
	end

	// Read back the addressed register
	always_comb begin
		unique case (idx)
			REG_SET_BITS:    prdata = PDATA_W'(cfg_q.index_len);
			REG_OFFSET_BITS: prdata = PDATA_W'(cfg_q.offset_len);
			REG_WAYS:        prdata = PDATA_W'(cfg_q.ways);
			default:         prdata = '0;
		endcase
	end

endmodule
`default_nettype wire

[hw/rtl/sac_mem.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// sac_mem: line store, one row per set holding every way
// Single write port, single registered read port; a clearing pass runs
// through every row after reset and holds busy high meanwhile.
// ----------------------------------------------------------------------------
module sac_mem #(
	parameter int ROW_W     = 512,
	parameter int ADDR_BITS = 8
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 rd_en,
	input  logic [ADDR_BITS-1:0] rd_addr,
	output logic [ROW_W-1:0]     rd_data,
	input  logic                 wr_en,
	input  logic [ADDR_BITS-1:0] wr_addr,
	input  logic [ROW_W-1:0]     wr_data,
	output logic                 busy
);
	localparam int ROWS = 1 << ADDR_BITS;

	logic [ROW_W-1:0]     mem [ROWS];
	logic [ROW_W-1:0]     rd_data_q;
	logic [ADDR_BITS-1:0] clr_addr_q;
	logic                 busy_q;

	assign busy    = busy_q;
	assign rd_data = rd_data_q;

	// Advance the clearing pass one row a cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q     <= 1'b1;
			clr_addr_q <= '0;
		end else if (busy_q) begin
			clr_addr_q <= clr_addr_q + 1'b1;
			if (clr_addr_q == '1) begin
				busy_q <= 1'b0;
			end
		end
	end

	// Write a row, clearing takes the port while busy
	always_ff @(posedge clk) begin
		if (busy_q) begin
			mem[clr_addr_q] <= '0;
		end else if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Register the read row
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

endmodule
`default_nettype wire

[bench/set_assoc_cache_lru_sim_top_test.sv]
// ----------------------------------------------------------------------------
// set_assoc_cache_lru_sim_top_test: self-checking bench for the LRU cache model
// Drives load, store, modify and fetch accesses through the request channel
// under several register settings. A behavioural copy of the cache predicts
// each outcome and the running totals. Every response transaction is
// compared field by field with the oldest prediction. Both channels idle at
// random, and the response side holds off for a long stretch at least once.
// ----------------------------------------------------------------------------
module set_assoc_cache_lru_sim_top_test;
	import sac_pkg::*;

	localparam int MAX_SET_BITS = 8;
	localparam int MAX_WAYS     = 8;
	localparam int ADDR_WIDTH   = 32;
	localparam int NUM_LINES    = MAX_WAYS << MAX_SET_BITS;
	localparam int QUIET_LIMIT  = 4000;
	localparam int SETTLE       = MAX_WAYS + 8;
	localparam int PHASE_ITEMS  = 150;

	typedef struct {
		outcome_t           outcome;
		logic               second_hit;
		logic [TOTAL_W-1:0] hits;
		logic [TOTAL_W-1:0] misses;
		logic [TOTAL_W-1:0] evictions;
	} access_result_t;

	logic                clk;
	logic                arst_n;
	logic                psel;
	logic                penable;
	logic                pwrite;
	logic [PADDR_W-1:0]  paddr;
	logic [PDATA_W-1:0]  pwdata;
	logic [PDATA_W-1:0]  prdata;
	logic                pready;

	sac_req_if req();
	sac_rsp_if rsp();

	// Cache image: valid bits, tags and use stamps of every line
	bit                 line_valid [NUM_LINES];
	logic [63:0]        line_tag   [NUM_LINES];
	logic [STAMP_W-1:0] line_stamp [NUM_LINES];
	logic [STAMP_W-1:0] use_clock;
	logic [TOTAL_W-1:0] hit_count;
	logic [TOTAL_W-1:0] miss_count;
	logic [TOTAL_W-1:0] evict_count;

	// Register image as written
	logic [SET_BITS_W-1:0]    cfg_index_len;
	logic [OFFSET_BITS_W-1:0] cfg_offset_len;
	logic [WAYS_CFG_W-1:0]    cfg_ways;

	access_result_t pending_results[$];
	int  error_count;
	int  result_index;
	bit  idle_on;
	int  hold_off_cycles;
	int  sink_pause;

	set_assoc_cache_lru_sim_top #(
		.MAX_SET_BITS(MAX_SET_BITS),
		.MAX_WAYS    (MAX_WAYS),
		.ADDR_WIDTH  (ADDR_WIDTH)
	) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.pready (pready)
	);

	always #4 clk = ~clk;

	function automatic void note_error(input string msg);
		error_count++;
		if (error_count <= 10) begin
			$display("ERROR: %s", msg);
		end
	endfunction

	function automatic logic [TOTAL_W-1:0] sat_inc(input logic [TOTAL_W-1:0] v);
		return (v == '1) ? v : v + 1'b1;
	endfunction

	// Clamp the registers the way the block uses them
	function automatic int unsigned eff_index_len();
		int unsigned s;
		s = cfg_index_len;
		if (s < 1) s = 1;
		if (s > MAX_SET_BITS) s = MAX_SET_BITS;
		return s;
	endfunction

	function automatic int unsigned eff_offset_len();
		return (cfg_offset_len == 0) ? 1 : cfg_offset_len;
	endfunction

	function automatic int unsigned eff_ways();
		int unsigned w;
		w = cfg_ways;
		if (w < 1) w = 1;
		if (w > MAX_WAYS) w = MAX_WAYS;
		return w;
	endfunction

	// Build an address from tag and set under the current split, random offset
	function automatic logic [ADDR_W-1:0] make_address(input int unsigned tag,
		input int unsigned set_no);
		int unsigned s;
		int unsigned b;
		logic [63:0] v;
		s = eff_index_len();
		b = eff_offset_len();
		v = (64'(tag) << (s + b)) | (64'(set_no) << b)
			| (64'($urandom) & ((64'd1 << b) - 1));
		return v[ADDR_W-1:0];
	endfunction

	// Look up one access in the cache image and queue the result it gives
	function automatic void predict_access(input cmd_t cmd, input logic [ADDR_W-1:0] addr);
		int unsigned s;
		int unsigned b;
		int unsigned ways;
		int unsigned base;
		int unsigned victim;
		int unsigned w;
		logic [63:0] a;
		logic [63:0] tag;
		logic [STAMP_W-1:0] stamp;
		logic [STAMP_W-1:0] oldest;
		bit hit;
		bit empty;
		access_result_t r;
		if (cmd == CMD_FETCH) return;
		s = eff_index_len();
		b = eff_offset_len();
		ways = eff_ways();
		a = 64'(addr);
		base = int'((a >> b) & ((64'd1 << s) - 1)) * MAX_WAYS;
		tag = a >> (s + b);
		stamp = use_clock;
		use_clock = use_clock + 1'b1;
		hit = 0;
		for (w = 0; w < ways && !hit; w++) begin
			if (line_valid[base + w] && line_tag[base + w] == tag) begin
				line_stamp[base + w] = stamp;
				hit = 1;
			end
		end
		if (hit) begin
			hit_count = sat_inc(hit_count);
			r.outcome = OUT_HIT;
		end else begin
			victim = 0;
			empty = 0;
			for (w = 0; w < ways && !empty; w++) begin
				if (!line_valid[base + w]) begin
					victim = w;
					empty = 1;
				end
			end
			if (empty) begin
				r.outcome = OUT_FILL;
			end else begin
				// Oldest stamp loses; the lowest way wins a tie for eviction
				oldest = line_stamp[base];
				for (w = 1; w < ways; w++) begin
					if (line_stamp[base + w] < oldest) begin
						oldest = line_stamp[base + w];
						victim = w;
					end
				end
				evict_count = sat_inc(evict_count);
				r.outcome = OUT_EVICT;
			end
			miss_count = sat_inc(miss_count);
			line_valid[base + victim] = 1;
			line_tag[base + victim] = tag;
			line_stamp[base + victim] = stamp;
		end
		if (cmd == CMD_MODIFY) hit_count = sat_inc(hit_count);
		r.second_hit = (cmd == CMD_MODIFY);
		r.hits = hit_count;
		r.misses = miss_count;
		r.evictions = evict_count;
		pending_results.push_back(r);
	endfunction

	// Offer one access, with an optional idle burst first, until it is taken
	task automatic send_access(input cmd_t cmd, input logic [ADDR_W-1:0] addr);
		@(negedge clk);
		if (idle_on && $urandom_range(0, 3) == 0) begin
			req.valid = 1'b0;
			repeat ($urandom_range(1, 4)) @(negedge clk);
		end
		req.valid = 1'b1;
		req.command = cmd;
		req.address = addr;
		do @(posedge clk); while (!req.ready);
		predict_access(cmd, addr);
	endtask

	task automatic apb_access(input reg_idx_t idx, input bit wr,
		input logic [PDATA_W-1:0] value, output logic [PDATA_W-1:0] rdata);
		@(negedge clk);
		psel = 1'b1;
		penable = 1'b0;
		pwrite = wr;
		paddr = PADDR_W'({idx, 2'b00});
		pwdata = value;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		rdata = prdata;
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
	endtask

	task automatic check_register(input reg_idx_t idx, input logic [PDATA_W-1:0] want);
		logic [PDATA_W-1:0] got;
		apb_access(idx, 1'b0, '0, got);
		if (got !== want) begin
			note_error($sformatf("register %s reads %0h, expected %0h", idx.name(), got, want));
		end
	endtask

	// Write one register, mirror it and read it back
	task automatic write_register(input reg_idx_t idx, input logic [PDATA_W-1:0] value);
		logic [PDATA_W-1:0] unused;
		apb_access(idx, 1'b1, value, unused);
		case (idx)
			REG_SET_BITS: begin
				cfg_index_len = value[SET_BITS_W-1:0];
				check_register(idx, PDATA_W'(cfg_index_len));
			end
			REG_OFFSET_BITS: begin
				cfg_offset_len = value[OFFSET_BITS_W-1:0];
				check_register(idx, PDATA_W'(cfg_offset_len));
			end
			default: begin
				cfg_ways = value[WAYS_CFG_W-1:0];
				check_register(idx, PDATA_W'(cfg_ways));
			end
		endcase
	endtask

	// Drop valid and wait until every predicted result has come back
	task automatic wait_drain();
		@(negedge clk);
		req.valid = 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic set_config(input int unsigned s, input int unsigned b, input int unsigned w);
		wait_drain();
		write_register(REG_SET_BITS, s);
		write_register(REG_OFFSET_BITS, b);
		write_register(REG_WAYS, w);
	endtask

	// Mostly accesses to a few sets with a few tags each, some wild addresses
	task automatic send_random(input int count, input bit toggle_idle);
		int i;
		int unsigned pick;
		int unsigned set_span;
		cmd_t cmd;
		logic [ADDR_W-1:0] addr;
		set_span = (1 << eff_index_len()) - 1;
		if (set_span > 3) set_span = 3;
		for (i = 0; i < count; i++) begin
			if (toggle_idle) idle_on = ((i / 50) % 2) == 0;
			pick = $urandom_range(0, 9);
			cmd = (pick < 3) ? CMD_LOAD : (pick < 6) ? CMD_STORE :
				(pick < 9) ? CMD_MODIFY : CMD_FETCH;
			if ($urandom_range(0, 4) == 0) begin
				addr = $urandom;
			end else begin
				addr = make_address($urandom_range(0, eff_ways() + 1),
					$urandom_range(0, set_span));
			end
			send_access(cmd, addr);
		end
	endtask

	task automatic test_register_reset();
		check_register(REG_SET_BITS, PDATA_W'(SET_BITS_RST));
		check_register(REG_OFFSET_BITS, PDATA_W'(OFFSET_BITS_RST));
		check_register(REG_WAYS, PDATA_W'(WAYS_RST));
	endtask

	// Fill, hit, modify, LRU eviction and ignored fetches with two ways per set
	task automatic test_directed();
		set_config(2, 4, 2);
		idle_on = 1'b1;
		send_access(CMD_LOAD, 32'h0000_0000);
		send_access(CMD_LOAD, 32'hFFFF_FFFF);
		send_access(CMD_STORE, 32'h0000_0000);
		send_access(CMD_MODIFY, make_address(1, 0));
		send_access(CMD_LOAD, make_address(2, 0));
		send_access(CMD_FETCH, make_address(2, 0));
		send_access(CMD_FETCH, 32'hFFFF_FFFF);
		send_access(CMD_LOAD, 32'h0000_0000);
		send_access(CMD_MODIFY, make_address(2, 0));
		send_access(CMD_STORE, make_address(1, 0));
		send_access(CMD_LOAD, 32'hFFFF_FFFF);
		send_access(CMD_MODIFY, 32'hFFFF_FFFF);
		send_access(CMD_STORE, make_address(1, 3));
		send_access(CMD_LOAD, make_address(2, 3));
		send_access(CMD_FETCH, 32'h0000_0000);
		send_access(CMD_LOAD, make_address(1, 3));
	endtask

	// Sweep settings, extremes and out-of-range values among them
	task automatic test_config_sweep();
		int unsigned s_list [8] = '{1, 8, 0, 15, 3, 8, 5, 2};
		int unsigned b_list [8] = '{1, 23, 0, 31, 2, 1, 12, 9};
		int unsigned w_list [8] = '{1, 8, 0, 15, 4, 3, 6, 8};
		int p;
		for (p = 0; p < 8; p++) begin
			set_config(s_list[p], b_list[p], w_list[p]);
			send_random(PHASE_ITEMS, 1'b1);
		end
	endtask

	// Hold the response side off while accesses keep coming
	task automatic test_backpressure();
		set_config(4, 4, 4);
		idle_on = 1'b0;
		hold_off_cycles = 200;
		send_random(40, 1'b0);
	endtask

	task automatic test_no_idle();
		set_config(3, 6, 8);
		idle_on = 1'b0;
		send_random(200, 1'b0);
	endtask

	// Drive the response ready: long hold-off first, then random pauses
	always @(negedge clk) begin
		if (hold_off_cycles > 0) begin
			rsp.ready = 1'b0;
			hold_off_cycles--;
		end else if (sink_pause > 0) begin
			rsp.ready = 1'b0;
			sink_pause--;
		end else if (idle_on && $urandom_range(0, 5) == 0) begin
			rsp.ready = 1'b0;
			sink_pause = $urandom_range(0, 3);
		end else begin
			rsp.ready = 1'b1;
		end
	end

	// Compare each response transaction with the oldest prediction
	always @(posedge clk) begin : check_response
		access_result_t want;
		if (rsp.valid && rsp.ready) begin
			if (pending_results.size() == 0) begin
				note_error($sformatf("response %0d arrived with nothing expected", result_index));
			end else begin
				want = pending_results.pop_front();
				if (rsp.outcome !== want.outcome || rsp.second_hit !== want.second_hit
					|| rsp.hit_total !== want.hits || rsp.miss_total !== want.misses
					|| rsp.eviction_total !== want.evictions) begin
					note_error($sformatf({"response %0d: outcome %0d/%0d second_hit %0b/%0b ",
						"hits %0d/%0d misses %0d/%0d evictions %0d/%0d (got/expected)"},
						result_index, rsp.outcome, want.outcome, rsp.second_hit,
						want.second_hit, rsp.hit_total, want.hits, rsp.miss_total,
						want.misses, rsp.eviction_total, want.evictions));
				end
			end
			result_index++;
		end
	end

	// End the run when nothing moves for too long
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || (psel && penable))
				quiet = 0;
			else
				quiet++;
		end
		$display("DONE: errors detected");
		$finish;
	end

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		req.valid = 1'b0;
		req.command = CMD_LOAD;
		req.address = '0;
		rsp.ready = 1'b0;
		cfg_index_len = SET_BITS_RST;
		cfg_offset_len = OFFSET_BITS_RST;
		cfg_ways = WAYS_RST;
		use_clock = '0;
		hit_count = '0;
		miss_count = '0;
		evict_count = '0;
		error_count = 0;
		result_index = 0;
		idle_on = 1'b0;
		hold_off_cycles = 0;
		sink_pause = 0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_register_reset();
		test_directed();
		test_config_sweep();
		test_backpressure();
		test_no_idle();
		wait_drain();

		if (pending_results.size() != 0)
			note_error($sformatf("%0d results never arrived", pending_results.size()));
		if (error_count == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule

[set_assoc_cache_lru_sim_top.f]
hw/rtl/sac_pkg.sv
hw/rtl/sac_if.sv
hw/rtl/sac_cfg.sv
hw/rtl/sac_mem.sv
hw/rtl/set_assoc_cache_lru_sim_top.sv
bench/set_assoc_cache_lru_sim_top_test.sv
